// File: sv/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, held off while reset is high.
`define LSI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// Clocked assertion that also holds through reset.
`define LSI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// File: sv/lsi_pkg.sv
// Package: widths and types for the segment intersection pipeline.
`timescale 1ns / 1ps
package lsi_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DIFW = COORD_BITS + 1;
  localparam int PW   = DIFW + COORD_BITS;
  localparam int DPW  = 2 * DIFW;
  localparam int CW   = 2 * COORD_BITS + 2;
  localparam int DENW = 2 * COORD_BITS + 3;
  localparam int MW   = DIFW + CW;
  localparam int NW   = 3 * COORD_BITS + 4;
  localparam int LW   = COORD_BITS + DENW + 1;
  localparam int QB   = COORD_BITS + FRAC_BITS;
  localparam int QXW  = (QB > 33) ? QB : 33;
  localparam int RW   = DENW + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;
  } seg_t;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic              neg_x;
    logic              neg_y;
    logic [DENW-1:0]   d;
    logic [RW-1:0]     rem_x;
    logic [RW-1:0]     rem_y;
    logic [QB-1:0]     rq_x;
    logic [QB-1:0]     rq_y;
  } cell_t;
endpackage

// File: sv/lsi_if.sv
// Interfaces: segment pair input channel and intersection result channel.
`timescale 1ns / 1ps
interface lsi_seg_if;
  logic valid;
  logic ready;
  logic signed [lsi_pkg::COORD_BITS-1:0] a_start_x;
  logic signed [lsi_pkg::COORD_BITS-1:0] a_start_y;
  logic signed [lsi_pkg::COORD_BITS-1:0] a_end_x;
  logic signed [lsi_pkg::COORD_BITS-1:0] a_end_y;
  logic signed [lsi_pkg::COORD_BITS-1:0] b_start_x;
  logic signed [lsi_pkg::COORD_BITS-1:0] b_start_y;
  logic signed [lsi_pkg::COORD_BITS-1:0] b_end_x;
  logic signed [lsi_pkg::COORD_BITS-1:0] b_end_y;
  modport source(output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                 b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink(input valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface lsi_res_if;
  logic valid;
  logic ready;
  logic found;
  logic signed [31:0] cross_x;
  logic signed [31:0] cross_y;
  modport source(output valid, found, cross_x, cross_y, input ready);
  modport sink(input valid, found, cross_x, cross_y, output ready);
endinterface

// File: sv/lsi_front.sv
// Front pipeline: line equations, denominator, numerators and range tests.
`timescale 1ns / 1ps
module lsi_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          v_in,
  input  lsi_pkg::seg_t seg,
  output lsi_pkg::cell_t fo
);
  localparam int CB = lsi_pkg::COORD_BITS;

  logic [6:1] v;

  // stage 1
  logic signed [CB-1:0] ax0, ay0, bx0, by0;
  logic signed [CB-1:0] lo1 [4], hi1 [4];
  logic [3:0] zs1;
  logic signed [lsi_pkg::DIFW-1:0] a1, b1, a2, b2;
  // stage 2
  logic signed [lsi_pkg::PW-1:0] p1, p2, p3, p4;
  logic signed [lsi_pkg::DPW-1:0] d1, d2;
  logic signed [lsi_pkg::DIFW-1:0] a1_2, b1_2, a2_2, b2_2;
  logic signed [CB-1:0] lo2 [4], hi2 [4];
  logic [3:0] zs2;
  // stage 3
  logic signed [lsi_pkg::CW-1:0] c1, c2;
  logic signed [lsi_pkg::DENW-1:0] den3;
  logic signed [lsi_pkg::DIFW-1:0] a1_3, b1_3, a2_3, b2_3;
  logic signed [CB-1:0] lo3 [4], hi3 [4];
  logic [3:0] zs3;
  // stage 4
  logic signed [lsi_pkg::MW-1:0] m1, m2, m3, m4;
  logic signed [lsi_pkg::DENW-1:0] den4;
  logic signed [CB-1:0] lo4 [4], hi4 [4];
  logic [3:0] zs4;
  // stage 5
  logic signed [lsi_pkg::NW-1:0] nx5, ny5;
  logic signed [lsi_pkg::DENW:0] den5;
  logic dz5;
  logic signed [CB-1:0] lo5 [4], hi5 [4];
  logic [3:0] zs5;
  // stage 6
  logic signed [lsi_pkg::LW-1:0] lp [4], hp [4];
  logic signed [lsi_pkg::NW-1:0] nx6, ny6;
  logic [lsi_pkg::DENW-1:0] den6;
  logic dz6;
  logic [3:0] zs6;

  logic signed [lsi_pkg::NW-1:0] nx5_next, ny5_next;
  logic signed [lsi_pkg::DENW:0] den5_next;
  logic [3:0] ok;
  logic [lsi_pkg::NW-1:0] mx, my;
  logic [lsi_pkg::NW+lsi_pkg::FRAC_BITS-1:0] sx, sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], v_in};
    end
  end

  always_comb begin
    nx5_next = lsi_pkg::NW'(m1) - lsi_pkg::NW'(m2);
    ny5_next = lsi_pkg::NW'(m3) - lsi_pkg::NW'(m4);
    den5_next = (lsi_pkg::DENW+1)'(den4);
    if (den4 < 0) begin
      nx5_next = -nx5_next;
      ny5_next = -ny5_next;
      den5_next = -den5_next;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ok[i] = !zs6[i] && lp[i] <= ((i < 2) ? nx6 : ny6)
              && ((i < 2) ? nx6 : ny6) <= hp[i];
    end
    mx = nx6[lsi_pkg::NW-1] ? lsi_pkg::NW'(-nx6) : lsi_pkg::NW'(nx6);
    my = ny6[lsi_pkg::NW-1] ? lsi_pkg::NW'(-ny6) : lsi_pkg::NW'(ny6);
    sx = (lsi_pkg::NW+lsi_pkg::FRAC_BITS)'(mx) << lsi_pkg::FRAC_BITS;
    sy = (lsi_pkg::NW+lsi_pkg::FRAC_BITS)'(my) << lsi_pkg::FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0 <= seg.a_start_x; ay0 <= seg.a_start_y;
      bx0 <= seg.b_start_x; by0 <= seg.b_start_y;
      a1 <= lsi_pkg::DIFW'(seg.a_end_y) - lsi_pkg::DIFW'(seg.a_start_y);
      b1 <= lsi_pkg::DIFW'(seg.a_start_x) - lsi_pkg::DIFW'(seg.a_end_x);
      a2 <= lsi_pkg::DIFW'(seg.b_end_y) - lsi_pkg::DIFW'(seg.b_start_y);
      b2 <= lsi_pkg::DIFW'(seg.b_start_x) - lsi_pkg::DIFW'(seg.b_end_x);
      // order: A x, B x, A y, B y
      lo1[0] <= (seg.a_start_x < seg.a_end_x) ? seg.a_start_x : seg.a_end_x;
      hi1[0] <= (seg.a_start_x < seg.a_end_x) ? seg.a_end_x : seg.a_start_x;
      lo1[1] <= (seg.b_start_x < seg.b_end_x) ? seg.b_start_x : seg.b_end_x;
      hi1[1] <= (seg.b_start_x < seg.b_end_x) ? seg.b_end_x : seg.b_start_x;
      lo1[2] <= (seg.a_start_y < seg.a_end_y) ? seg.a_start_y : seg.a_end_y;
      hi1[2] <= (seg.a_start_y < seg.a_end_y) ? seg.a_end_y : seg.a_start_y;
      lo1[3] <= (seg.b_start_y < seg.b_end_y) ? seg.b_start_y : seg.b_end_y;
      hi1[3] <= (seg.b_start_y < seg.b_end_y) ? seg.b_end_y : seg.b_start_y;
      zs1 <= {seg.b_start_y == seg.b_end_y, seg.a_start_y == seg.a_end_y,
              seg.b_start_x == seg.b_end_x, seg.a_start_x == seg.a_end_x};

      p1 <= a1 * ax0;
      p2 <= b1 * ay0;
      p3 <= a2 * bx0;
      p4 <= b2 * by0;
      d1 <= a1 * b2;
      d2 <= a2 * b1;
      a1_2 <= a1; b1_2 <= b1; a2_2 <= a2; b2_2 <= b2;
      lo2 <= lo1; hi2 <= hi1; zs2 <= zs1;

      c1 <= lsi_pkg::CW'(p1) + lsi_pkg::CW'(p2);
      c2 <= lsi_pkg::CW'(p3) + lsi_pkg::CW'(p4);
      den3 <= lsi_pkg::DENW'(d1) - lsi_pkg::DENW'(d2);
      a1_3 <= a1_2; b1_3 <= b1_2; a2_3 <= a2_2; b2_3 <= b2_2;
      lo3 <= lo2; hi3 <= hi2; zs3 <= zs2;

      m1 <= b2_3 * c1;
      m2 <= b1_3 * c2;
      m3 <= a1_3 * c2;
      m4 <= a2_3 * c1;
      den4 <= den3;
      lo4 <= lo3; hi4 <= hi3; zs4 <= zs3;

      nx5 <= nx5_next;
      ny5 <= ny5_next;
      den5 <= den5_next;
      dz5 <= den4 == '0;
      lo5 <= lo4; hi5 <= hi4; zs5 <= zs4;

      for (int i = 0; i < 4; i++) begin
        lp[i] <= lo5[i] * den5;
        hp[i] <= hi5[i] * den5;
      end
      nx6 <= nx5;
      ny6 <= ny5;
      den6 <= den5[lsi_pkg::DENW-1:0];
      dz6 <= dz5;
      zs6 <= zs5;

      fo.found <= !dz6 && (ok[0] || ok[2]) && (ok[1] || ok[3]);
      fo.neg_x <= nx6[lsi_pkg::NW-1];
      fo.neg_y <= ny6[lsi_pkg::NW-1];
      fo.d <= den6;
      fo.rem_x <= sx[lsi_pkg::NW+lsi_pkg::FRAC_BITS-1:lsi_pkg::QB];
      fo.rem_y <= sy[lsi_pkg::NW+lsi_pkg::FRAC_BITS-1:lsi_pkg::QB];
      fo.rq_x <= sx[lsi_pkg::QB-1:0];
      fo.rq_y <= sy[lsi_pkg::QB-1:0];
    end
    if (rst) begin
      fo.valid <= 1'b0;
    end else if (en) begin
      fo.valid <= v[6];
    end
  end
endmodule

// File: sv/lsi_div_cell.sv
// Divider cell: one restoring quotient bit for x and y, registered.
`timescale 1ns / 1ps
module lsi_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  lsi_pkg::cell_t ci,
  output lsi_pkg::cell_t co
);
  logic [lsi_pkg::RW:0] tx, ty, dd;
  logic gx, gy;

  always_comb begin
    dd = (lsi_pkg::RW+1)'(ci.d);
    tx = {ci.rem_x, ci.rq_x[lsi_pkg::QB-1]};
    ty = {ci.rem_y, ci.rq_y[lsi_pkg::QB-1]};
    gx = tx >= dd;
    gy = ty >= dd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      co.valid <= 1'b0;
    end else if (en) begin
      co.valid <= ci.valid;
    end
    if (en) begin
      co.found <= ci.found;
      co.neg_x <= ci.neg_x;
      co.neg_y <= ci.neg_y;
      co.d <= ci.d;
      co.rem_x <= lsi_pkg::RW'(gx ? tx - dd : tx);
      co.rem_y <= lsi_pkg::RW'(gy ? ty - dd : ty);
      co.rq_x <= {ci.rq_x[lsi_pkg::QB-2:0], gx};
      co.rq_y <= {ci.rq_y[lsi_pkg::QB-2:0], gy};
    end
  end
endmodule

// File: sv/line_segment_intersection.sv
// Top level: segment intersection pipeline with a chain of divider cells.
// Takes one segment pair per cycle while no result waits, and returns found plus the
// crossing point in signed Q16.16, truncated toward zero (zero when not found). The
// pipeline has seven front stages for the line equations, numerators and range tests,
// one divider cell per quotient bit, and the output register. The whole pipe holds
// while a result waits.
`timescale 1ns / 1ps
module line_segment_intersection (
  input logic      clk,
  input logic      rst,
  lsi_seg_if.sink  seg,
  lsi_res_if.source res
);
  localparam int QB = lsi_pkg::QB;

  logic en;
  lsi_pkg::seg_t sd;
  lsi_pkg::cell_t chain [QB+1];
  lsi_pkg::cell_t last;
  logic [lsi_pkg::QXW-1:0] qx, qy, lim_x, lim_y, sat_x, sat_y;
  logic [31:0] vx, vy;

  assign en = !res.valid || res.ready;
  assign seg.ready = en;

  assign sd = '{a_start_x: seg.a_start_x, a_start_y: seg.a_start_y,
                a_end_x: seg.a_end_x, a_end_y: seg.a_end_y,
                b_start_x: seg.b_start_x, b_start_y: seg.b_start_y,
                b_end_x: seg.b_end_x, b_end_y: seg.b_end_y};

  lsi_front u_front (
    .clk(clk), .rst(rst), .en(en), .v_in(seg.valid), .seg(sd), .fo(chain[0])
  );

  for (genvar i = 0; i < QB; i++) begin : g_cell
    lsi_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .ci(chain[i]), .co(chain[i+1])
    );
  end

  assign last = chain[QB];

  always_comb begin
    qx = lsi_pkg::QXW'(last.rq_x);
    qy = lsi_pkg::QXW'(last.rq_y);
    lim_x = last.neg_x ? lsi_pkg::QXW'(33'h080000000) : lsi_pkg::QXW'(33'h07fffffff);
    lim_y = last.neg_y ? lsi_pkg::QXW'(33'h080000000) : lsi_pkg::QXW'(33'h07fffffff);
    sat_x = (qx > lim_x) ? lim_x : qx;
    sat_y = (qy > lim_y) ? lim_y : qy;
    vx = last.neg_x ? -sat_x[31:0] : sat_x[31:0];
    vy = last.neg_y ? -sat_y[31:0] : sat_y[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.found <= last.found;
      res.cross_x <= last.found ? vx : '0;
      res.cross_y <= last.found ? vy : '0;
    end
  end
endmodule

// File: sv/lsi_checker.sv
// Port checker for the segment intersection block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lsi_checker (
  input logic        clk,
  input logic        rst,
  input logic        seg_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        found,
  input logic [31:0] cross_x,
  input logic [31:0] cross_y
);
  `LSI_ASSERT(a_miss_zero, clk, rst, res_valid && !found |-> cross_x == 0 && cross_y == 0)
  `LSI_ASSERT(a_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(cross_x) && $stable(cross_y) && $stable(found))
  `LSI_ASSERT(a_stall, clk, rst, res_valid && !res_ready |-> !seg_ready)
  `LSI_ASSERT_ALWAYS(a_reset, clk, rst |=> !res_valid)
endmodule

bind line_segment_intersection lsi_checker u_lsi_checker (
  .clk(clk), .rst(rst), .seg_ready(seg.ready), .res_valid(res.valid),
  .res_ready(res.ready), .found(res.found), .cross_x(res.cross_x),
  .cross_y(res.cross_y)
);

// File: bench/lsi_crossing_checker.sv
// Checker: predicts each segment pair's crossing result and compares it with the result channel.
`timescale 1ns / 1ps
module lsi_crossing_checker (
  input  logic clk,
  input  logic rst,
  lsi_seg_if   seg,
  lsi_res_if   res,
  output int   errors,
  output int   pending
);
  import lsi_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic        found;
    logic [31:0] cross_x;
    logic [31:0] cross_y;
  } crossing_t;

  crossing_t crossings_due[$];

  function automatic logic on_span(wide_t e0, wide_t e1, wide_t num, wide_t den);
    wide_t lo;
    wide_t hi;
    if (e0 == e1) return 1'b0;
    lo = (e0 < e1) ? e0 : e1;
    hi = (e0 < e1) ? e1 : e0;
    return (lo * den <= num) && (num <= hi * den);
  endfunction

  function automatic logic [31:0] to_q(wide_t num, wide_t den);
    logic  neg;
    wide_t mag;
    wide_t quo;
    wide_t lim;
    wide_t v;
    neg = num < 0;
    mag = neg ? -num : num;
    lim = neg ? (wide_t'(1) <<< 31) : ((wide_t'(1) <<< 31) - 1);
    quo = (mag <<< FRAC_BITS) / den;
    v = (quo > lim) ? lim : quo;
    v = neg ? -v : v;
    return v[31:0];
  endfunction

  function automatic crossing_t solve_crossing(seg_t s);
    wide_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    wide_t a1, b1, c1, a2, b2, c2, den, nx, ny;
    crossing_t r;
    ax0 = s.a_start_x; ay0 = s.a_start_y; ax1 = s.a_end_x; ay1 = s.a_end_y;
    bx0 = s.b_start_x; by0 = s.b_start_y; bx1 = s.b_end_x; by1 = s.b_end_y;
    a1 = ay1 - ay0; b1 = ax0 - ax1; c1 = a1 * ax0 + b1 * ay0;
    a2 = by1 - by0; b2 = bx0 - bx1; c2 = a2 * bx0 + b2 * by0;
    den = a1 * b2 - a2 * b1;
    r = '0;
    if (den == 0) return r;
    nx = b2 * c1 - b1 * c2;
    ny = a1 * c2 - a2 * c1;
    if (den < 0) begin
      den = -den;
      nx = -nx;
      ny = -ny;
    end
    if ((on_span(ax0, ax1, nx, den) || on_span(ay0, ay1, ny, den)) &&
        (on_span(bx0, bx1, nx, den) || on_span(by0, by1, ny, den))) begin
      r.found = 1'b1;
      r.cross_x = to_q(nx, den);
      r.cross_y = to_q(ny, den);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    seg_t s;
    crossing_t want;
    if (!rst) begin
      if (seg.valid && seg.ready) begin
        s = '{seg.a_start_x, seg.a_start_y, seg.a_end_x, seg.a_end_y,
              seg.b_start_x, seg.b_start_y, seg.b_end_x, seg.b_end_y};
        crossings_due.push_back(solve_crossing(s));
      end
      if (res.valid && res.ready) begin
        if (crossings_due.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = crossings_due.pop_front();
          if (res.found !== want.found)
            report_mismatch("found", res.found, want.found);
          if (res.cross_x !== want.cross_x)
            report_mismatch("cross_x", $signed(res.cross_x), $signed(want.cross_x));
          if (res.cross_y !== want.cross_y)
            report_mismatch("cross_y", $signed(res.cross_y), $signed(want.cross_y));
        end
      end
      pending = crossings_due.size();
    end
  end
endmodule

// File: bench/testbench.sv
// Testbench top: drives segment pairs, paces the result side and reports the verdict.
`timescale 1ns / 1ps
module testbench;
  import lsi_pkg::*;

  localparam int N_RANDOM = 730;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  logic calm;
  logic long_hold;
  int   quiet_cycles;

  lsi_seg_if seg_ch();
  lsi_res_if res_ch();

  line_segment_intersection i_dut (.clk(clk), .rst(rst), .seg(seg_ch), .res(res_ch));

  lsi_crossing_checker i_checker (
    .clk(clk), .rst(rst), .seg(seg_ch), .res(res_ch), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic seg_t pair(int ax0, int ay0, int ax1, int ay1,
                                int bx0, int by0, int bx1, int by1);
    return '{ax0[15:0], ay0[15:0], ax1[15:0], ay1[15:0],
             bx0[15:0], by0[15:0], bx1[15:0], by1[15:0]};
  endfunction

  function automatic int rand_coord(int span);
    logic [15:0] w;
    if (span >= 32767) begin
      w = 16'($urandom());
      return $signed(w);
    end
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic seg_t random_pair();
    int span;
    int c[8];
    int dx, dy;
    case ($urandom_range(0, 3))
      0: span = 4;
      1: span = 100;
      2: span = 5000;
      default: span = 32767;
    endcase
    foreach (c[i]) c[i] = rand_coord(span);
    case ($urandom_range(0, 9))
      0: begin
        // parallel or collinear copy of A
        dx = rand_coord(span > 8000 ? 8000 : span);
        dy = rand_coord(span > 8000 ? 8000 : span);
        if (span > 8000) foreach (c[i]) c[i] = rand_coord(8000);
        c[4] = c[0] + dx; c[5] = c[1] + dy;
        c[6] = c[4] + c[2] - c[0]; c[7] = c[5] + c[3] - c[1];
      end
      1: begin
        c[2] = c[0];
        if ($urandom_range(0, 1)) c[3] = c[1];
      end
      2: begin
        c[7] = c[5];
        if ($urandom_range(0, 1)) c[6] = c[4];
      end
      3: begin
        // B passes through an end of A
        c[4] = c[2]; c[5] = c[3];
      end
      default: ;
    endcase
    return pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  task automatic send_pair(seg_t s);
    if (!calm && $urandom_range(0, 7) == 0) begin
      seg_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    seg_ch.valid = 1'b1;
    {seg_ch.a_start_x, seg_ch.a_start_y, seg_ch.a_end_x, seg_ch.a_end_y,
     seg_ch.b_start_x, seg_ch.b_start_y, seg_ch.b_end_x, seg_ch.b_end_y} = s;
    do @(posedge clk); while (!seg_ch.ready);
    @(negedge clk);
  endtask

  // result side pacing
  initial begin
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        res_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        res_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (seg_ch.valid && seg_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    seg_t directed[$];
    rst = 1'b1;
    calm = 1'b0;
    long_hold = 1'b0;
    quiet_cycles = 0;
    seg_ch.valid = 1'b0;
    {seg_ch.a_start_x, seg_ch.a_start_y, seg_ch.a_end_x, seg_ch.a_end_y,
     seg_ch.b_start_x, seg_ch.b_start_y, seg_ch.b_end_x, seg_ch.b_end_y} = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    directed.push_back(pair(0, 0, 10, 10, 0, 10, 10, 0));
    directed.push_back(pair(0, 0, 3, 1, 0, 1, 3, 0));
    directed.push_back(pair(0, 0, 10, 0, 0, 5, 10, 5));
    directed.push_back(pair(0, 0, 10, 10, 5, 5, 20, 20));
    directed.push_back(pair(0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(pair(5, -5, 5, 5, -5, 0, 5, 0));
    directed.push_back(pair(0, -5, 0, 5, -5, 0, 5, 0));
    directed.push_back(pair(0, 0, 10, 10, 20, 0, 30, -10));
    directed.push_back(pair(0, 0, 4, 4, 4, 4, 8, 0));
    directed.push_back(pair(3, 3, 3, 3, 0, 0, 6, 6));
    directed.push_back(pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    directed.push_back(pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    directed.push_back(pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
    directed.push_back(pair(-32768, -32768, -32768, 32767, -32768, -32768, 32767, -32768));
    directed.push_back(pair(-32768, -32767, 32767, 32767, -32767, -32768, 32767, 32766));
    directed.push_back(pair(-1, -1, 1, 1, -1, 1, 1, -1));
    directed.push_back(pair(-7, -3, -1, -9, -8, -8, -2, -2));
    directed.push_back(pair(32767, 0, 32767, 1, 0, 0, 1, 0));
    directed.push_back(pair(-32768, -32768, -32767, -32766, 32767, 32767, 32766, 32765));
    directed.push_back(pair(0, 0, 1, 3, 0, 1, 1, 1));
    foreach (directed[i]) send_pair(directed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 100 && n < 160) || (n >= N_RANDOM - 150);
      if (n == 300) long_hold = 1'b1;
      if (n == 500) begin
        seg_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      send_pair(random_pair());
    end
    seg_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
